// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros
// concurrent checks on the rising clock edge, switched off for synthesis
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// condition holds at every edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// consequent holds at the edge where the antecedent holds
`define ASSERT_IMPLIES(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define ASSERT_IMPLIES(lbl, clk, rst_n, pre, post, msg)
`endif

`endif

// ===== rtl/kdhc_pkg.sv =====
// ---------------------------------------------------------------------------
// kdhc_pkg
// types, constants and helper functions of the decimal k-mer hash codec
// ---------------------------------------------------------------------------
package kdhc_pkg;

    localparam int MAX_DIGITS_DEF = 20;
    localparam int CFG_W          = 5;
    localparam int MODE_W         = 2;
    localparam int BASE_W         = 8;
    localparam int CODE_W         = 64;
    localparam int HASH_W         = 64;
    localparam int LETTER_W       = 8;
    localparam int DIGIT_W        = 4;
    localparam int MAC_W          = HASH_W + 5;
    localparam int CODE_BYTES     = CODE_W / 8;
    localparam int BYTE_CNT_W     = $clog2(CODE_BYTES);
    localparam int S_TDATA_W      = BASE_W + CODE_W;
    localparam int M_TDATA_RAW_W  = 2 * HASH_W + 1 + LETTER_W;
    localparam int M_TDATA_W      = ((M_TDATA_RAW_W + 7) / 8) * 8;

    localparam logic [MODE_W-1:0] MODE_ENCODE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DEC_FWD = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DEC_RC  = 2'd2;

    localparam logic [CFG_W-1:0]   MAX_BASES_RST = 5'd20;
    localparam logic [DIGIT_W-1:0] RADIX         = 4'd10;
    localparam logic [DIGIT_W-1:0] DIGIT_OTHER   = 4'd5;

    localparam logic [LETTER_W-1:0] CH_A_UP = 8'h41;
    localparam logic [LETTER_W-1:0] CH_C_UP = 8'h43;
    localparam logic [LETTER_W-1:0] CH_G_UP = 8'h47;
    localparam logic [LETTER_W-1:0] CH_T_UP = 8'h54;
    localparam logic [LETTER_W-1:0] CH_A_LO = 8'h61;
    localparam logic [LETTER_W-1:0] CH_C_LO = 8'h63;
    localparam logic [LETTER_W-1:0] CH_G_LO = 8'h67;
    localparam logic [LETTER_W-1:0] CH_T_LO = 8'h74;
    localparam logic [LETTER_W-1:0] CH_N_UP = 8'h4E;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENC_FWD,
        ST_ENC_PROD,
        ST_ENC_REV,
        ST_ENC_POW,
        ST_ENC_OUT,
        ST_DEC_DIV,
        ST_DEC_OUT
    } t_state;

    typedef struct packed {
        logic [7:0]         quot;
        logic [DIGIT_W-1:0] rem;
    } t_div_res;

    // base byte to digit, complemented digit when comp is set
    function automatic logic [DIGIT_W-1:0] base_digit(input logic [BASE_W-1:0] b,
                                                      input logic comp);
        logic [DIGIT_W-1:0] d;
        case (b)
            CH_A_UP: d = comp ? 4'd4 : 4'd1;
            CH_C_UP: d = comp ? 4'd3 : 4'd2;
            CH_G_UP: d = comp ? 4'd2 : 4'd3;
            CH_T_UP: d = comp ? 4'd1 : 4'd4;
            CH_A_LO: d = comp ? 4'd9 : 4'd6;
            CH_C_LO: d = comp ? 4'd8 : 4'd7;
            CH_G_LO: d = comp ? 4'd7 : 4'd8;
            CH_T_LO: d = comp ? 4'd6 : 4'd9;
            default: d = DIGIT_OTHER;
        endcase
        return d;
    endfunction

    function automatic logic [LETTER_W-1:0] letter_fwd(input logic [DIGIT_W-1:0] d);
        logic [LETTER_W-1:0] c;
        case (d)
            4'd1:    c = CH_A_UP;
            4'd2:    c = CH_C_UP;
            4'd3:    c = CH_G_UP;
            4'd4:    c = CH_T_UP;
            4'd6:    c = CH_A_LO;
            4'd7:    c = CH_C_LO;
            4'd8:    c = CH_G_LO;
            4'd9:    c = CH_T_LO;
            default: c = CH_N_UP;
        endcase
        return c;
    endfunction

    function automatic logic [LETTER_W-1:0] letter_rc(input logic [DIGIT_W-1:0] d);
        logic [LETTER_W-1:0] c;
        case (d)
            4'd1:    c = CH_T_UP;
            4'd2:    c = CH_G_UP;
            4'd3:    c = CH_C_UP;
            4'd4:    c = CH_A_UP;
            4'd6:    c = CH_T_LO;
            4'd7:    c = CH_G_LO;
            4'd8:    c = CH_C_LO;
            4'd9:    c = CH_A_LO;
            default: c = CH_N_UP;
        endcase
        return c;
    endfunction

    // one byte of a long division by ten, restoring, one bit a step
    function automatic t_div_res div10_byte(input logic [DIGIT_W-1:0] rem_in,
                                            input logic [7:0] byte_in);
        t_div_res           res;
        logic [DIGIT_W-1:0] r;
        logic [DIGIT_W:0]   t;
        r = rem_in;
        res.quot = '0;
        for (int i = 7; i >= 0; i--) begin
            t = {r, byte_in[i]};
            if (t >= {1'b0, RADIX}) begin
                res.quot[i] = 1'b1;
                r = DIGIT_W'(t - {1'b0, RADIX});
            end else begin
                r = t[DIGIT_W-1:0];
            end
        end
        res.rem = r;
        return res;
    endfunction

endpackage

// ===== rtl/kmer_decimal_hash_codec_unit.sv =====
// ---------------------------------------------------------------------------
// kmer_decimal_hash_codec_unit
// decimal k-mer hash encoder and decimal-to-letter decoder
// ---------------------------------------------------------------------------
// usage
//   slave channel: tuser carries the mode, tlast marks the final base of a
//   k-mer, tdata carries the base byte and the 64-bit code to decode
//   master channel: tuser is the kind (0 hash, 1 letter), tlast the end of a
//   run, tdata the two hashes, the overflow flag and the letter
//   config: i_cfg_wr_en writes max_bases from i_cfg_wr_data at once
// timing
//   the block takes one transfer at a time; s_axis_tready is high only
//   while the sequencer is idle
//   encode: a base within the limit passes through the shared multiply-add
//   unit in order (forward step, digit product, revcomp add, power step)
//   before the next base is taken; a base past the limit is dropped in idle;
//   with tlast the emit step loads the hash once the output register is free
//   decode: each decimal digit is one division by ten over all code bytes,
//   one byte per cycle, then the letters are emitted in order, at most MAX_DIGITS letters
// reset
//   max_bases returns to 20, the k-mer state is cleared, no result pending
// stall
//   a result waits in the output register; while the receiver holds
//   m_axis_tready low the sequencer waits at its emit step
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module kmer_decimal_hash_codec_unit
    import kdhc_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_W-1:0]     i_cfg_wr_data,
    // slave side
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // base[7:0], code[71:8]
    input  logic                 s_axis_tlast,   // last
    input  logic [MODE_W-1:0]    s_axis_tuser,   // mode[1:0]
    // master side
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // hash_forward[63:0],
                                                 // hash_revcomp[127:64],
                                                 // overflow[128],
                                                 // letter[136:129], zeros
    output logic                 m_axis_tlast,   // end_of_run
    output logic                 m_axis_tuser    // kind
);

    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam logic [BYTE_CNT_W-1:0] LAST_BYTE = BYTE_CNT_W'(CODE_BYTES - 1);

    // sequencer
    t_state r_state, n_state;

    // configuration and k-mer state
    logic [CFG_W-1:0]   r_max_bases;
    logic [HASH_W-1:0]  r_fwd, r_rev, r_pow, r_prod;
    logic [CFG_W-1:0]   r_bases;
    logic               r_ov;
    logic               r_last;
    logic [DIGIT_W-1:0] r_dig, r_cdig;

    // decoder state
    logic [CODE_W-1:0]     r_val;
    logic [DIGIT_W-1:0]    r_rem;
    logic [BYTE_CNT_W-1:0] r_byte;
    logic [CW-1:0]         r_n, r_k;
    logic                  r_dec_rc;
    logic [DIGIT_W-1:0]    r_buf [MAX_DIGITS];

    // output register
    logic                 r_m_tvalid;
    logic [M_TDATA_W-1:0] r_m_tdata;
    logic                 r_m_tlast;
    logic                 r_m_tuser;

    // shared multiply-add unit: a * m + b, full width for overflow
    logic [HASH_W-1:0]  w_mac_a, w_mac_b;
    logic [DIGIT_W-1:0] w_mac_m;
    logic [MAC_W-1:0]   w_mac_res;
    logic               w_mac_hi;

    logic               w_in_xfer, w_slot_free, w_take;
    logic [CFG_W-1:0]   w_limit;
    logic               w_load_hash, w_load_letter;
    t_div_res           w_div;
    logic [CODE_W-1:0]  w_quot;
    logic               w_digit_done, w_dec_stop;
    logic [CW-1:0]      w_rd_cnt;
    logic [DIGIT_W-1:0] w_rd_digit;
    logic [LETTER_W-1:0] w_letter;

    assign w_in_xfer   = s_axis_tvalid && s_axis_tready;
    assign w_slot_free = !r_m_tvalid || m_axis_tready;

    // effective base limit, clamped to 1..MAX_DIGITS
    always_comb begin
        if (r_max_bases == '0) begin
            w_limit = CFG_W'(1);
        end else if (r_max_bases > CFG_W'(MAX_DIGITS)) begin
            w_limit = CFG_W'(MAX_DIGITS);
        end else begin
            w_limit = r_max_bases;
        end
    end
    assign w_take = (r_bases < w_limit);

    assign w_mac_res = MAC_W'(w_mac_a) * MAC_W'(w_mac_m) + MAC_W'(w_mac_b);
    assign w_mac_hi  = |w_mac_res[MAC_W-1:HASH_W];

    // division by ten, top byte of the value each cycle
    assign w_div        = div10_byte(r_rem, r_val[CODE_W-1 -: 8]);
    assign w_quot       = {r_val[CODE_W-9:0], w_div.quot};
    assign w_digit_done = (r_byte == LAST_BYTE);
    assign w_dec_stop   = (w_quot == '0) || ((r_n + CW'(1)) >= CW'(MAX_DIGITS));

    // letter readout: forward runs from the most significant digit
    assign w_rd_cnt   = r_dec_rc ? r_k : (r_n - CW'(1) - r_k);
    assign w_rd_digit = r_buf[w_rd_cnt[IW-1:0]];
    assign w_letter   = r_dec_rc ? letter_rc(w_rd_digit) : letter_fwd(w_rd_digit);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    if (s_axis_tuser == MODE_ENCODE) begin
                        if (w_take) begin
                            n_state = ST_ENC_FWD;
                        end else if (s_axis_tlast) begin
                            n_state = ST_ENC_OUT;
                        end
                    end else if (s_axis_tuser == MODE_DEC_FWD ||
                                 s_axis_tuser == MODE_DEC_RC) begin
                        n_state = ST_DEC_DIV;
                    end
                end
            end
            ST_ENC_FWD:  n_state = ST_ENC_PROD;
            ST_ENC_PROD: n_state = ST_ENC_REV;
            ST_ENC_REV:  n_state = ST_ENC_POW;
            ST_ENC_POW:  n_state = r_last ? ST_ENC_OUT : ST_IDLE;
            ST_ENC_OUT: begin
                if (w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_DEC_DIV: begin
                if (w_digit_done && w_dec_stop) begin
                    n_state = ST_DEC_OUT;
                end
            end
            ST_DEC_OUT: begin
                if (w_slot_free && (r_k == r_n - CW'(1))) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs: ready, operand selection, output loads
    always_comb begin
        s_axis_tready = 1'b0;
        w_mac_a       = r_pow;
        w_mac_m       = RADIX;
        w_mac_b       = '0;
        w_load_hash   = 1'b0;
        w_load_letter = 1'b0;
        case (r_state)
            ST_IDLE:     s_axis_tready = 1'b1;
            ST_ENC_FWD: begin
                w_mac_a = r_fwd;
                w_mac_b = HASH_W'(r_dig);
            end
            ST_ENC_PROD: w_mac_m = r_cdig;
            ST_ENC_REV: begin
                w_mac_a = r_prod;
                w_mac_m = DIGIT_W'(1);
                w_mac_b = r_rev;
            end
            ST_ENC_POW:  w_mac_m = RADIX;
            ST_ENC_OUT:  w_load_hash = w_slot_free;
            ST_DEC_DIV:  ;
            ST_DEC_OUT:  w_load_letter = w_slot_free;
            default:     ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_max_bases <= MAX_BASES_RST;
            r_fwd       <= '0;
            r_rev       <= '0;
            r_pow       <= HASH_W'(1);
            r_bases     <= '0;
            r_ov        <= 1'b0;
            r_n         <= '0;
            r_k         <= '0;
            r_m_tvalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_max_bases <= i_cfg_wr_data;
            end
            case (r_state)
                ST_ENC_FWD: begin
                    r_fwd <= w_mac_res[HASH_W-1:0];
                    r_ov  <= r_ov | w_mac_hi;
                end
                ST_ENC_PROD: r_ov <= r_ov | w_mac_hi;
                ST_ENC_REV: begin
                    r_rev <= w_mac_res[HASH_W-1:0];
                    r_ov  <= r_ov | w_mac_hi;
                end
                ST_ENC_POW: begin
                    r_pow   <= w_mac_res[HASH_W-1:0];
                    r_bases <= r_bases + CFG_W'(1);
                end
                ST_ENC_OUT: begin
                    // hash handed over, start a fresh k-mer
                    if (w_load_hash) begin
                        r_fwd   <= '0;
                        r_rev   <= '0;
                        r_pow   <= HASH_W'(1);
                        r_bases <= '0;
                        r_ov    <= 1'b0;
                    end
                end
                ST_IDLE: begin
                    if (w_in_xfer) begin
                        r_n <= '0;
                        r_k <= '0;
                    end
                end
                ST_DEC_DIV: begin
                    if (w_digit_done) begin
                        r_n <= r_n + CW'(1);
                    end
                end
                ST_DEC_OUT: begin
                    if (w_load_letter) begin
                        r_k <= r_k + CW'(1);
                    end
                end
                default: ;
            endcase
            if (w_load_hash || w_load_letter) begin
                r_m_tvalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_last   <= s_axis_tlast;
            r_dig    <= base_digit(s_axis_tdata[BASE_W-1:0], 1'b0);
            r_cdig   <= base_digit(s_axis_tdata[BASE_W-1:0], 1'b1);
            r_dec_rc <= (s_axis_tuser == MODE_DEC_RC);
            r_val    <= s_axis_tdata[S_TDATA_W-1:BASE_W];
            r_rem    <= '0;
            r_byte   <= '0;
        end
        if (r_state == ST_ENC_PROD) begin
            r_prod <= w_mac_res[HASH_W-1:0];
        end
        if (r_state == ST_DEC_DIV) begin
            r_val  <= w_quot;
            r_byte <= r_byte + BYTE_CNT_W'(1);
            if (w_digit_done) begin
                r_buf[r_n[IW-1:0]] <= w_div.rem;
                r_rem <= '0;
            end else begin
                r_rem <= w_div.rem;
            end
        end
        if (w_load_hash) begin
            r_m_tdata <= M_TDATA_W'({{LETTER_W{1'b0}}, r_ov, r_rev, r_fwd});
            r_m_tlast <= 1'b1;
            r_m_tuser <= 1'b0;
        end else if (w_load_letter) begin
            r_m_tdata <= M_TDATA_W'({w_letter, 1'b0, {HASH_W{1'b0}}, {HASH_W{1'b0}}});
            r_m_tlast <= (r_k == r_n - CW'(1));
            r_m_tuser <= 1'b1;
        end
    end

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tlast  = r_m_tlast;
    assign m_axis_tuser  = r_m_tuser;

    // checks
    `ASSERT_ALWAYS(a_bases_bound, i_clk, i_rst_n, r_bases <= CFG_W'(MAX_DIGITS),
                   "bases taken past the digit limit")
    `ASSERT_IMPLIES(a_rem_digit, i_clk, i_rst_n, r_state == ST_DEC_DIV, r_rem < RADIX,
                    "division remainder is not a decimal digit")
    `ASSERT_IMPLIES(a_run_nonempty, i_clk, i_rst_n, r_state == ST_DEC_OUT,
                    (r_n != '0) && (r_n <= CW'(MAX_DIGITS)),
                    "letter run with no digits or too many")
    `ASSERT_IMPLIES(a_read_in_run, i_clk, i_rst_n, r_state == ST_DEC_OUT, r_k < r_n,
                    "letter read beyond the stored digits")

endmodule

// ===== tb/sv/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the decimal k-mer hash codec: a scoreboard class
// predicts hashes and decoded letters for every accepted transfer and
// compares each output transfer field by field, under changing max_bases
// settings and several idling and back-pressure patterns
// ---------------------------------------------------------------------------
module tb
    import kdhc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // mode 3 is not a real operation, the block drops it
    localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;

    // drain time after the last expected result, covers a full 20-digit decode
    localparam int DRAIN_CYCLES   = 250;
    // cycles without any transfer before giving up
    localparam int WATCHDOG_LIMIT = 4000;
    // length of the receiver hold-off that fills the block
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_ITEMS    = 33;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idling;

    // one output transfer as the scoreboard sees it
    typedef struct packed {
        logic                kind;
        logic [HASH_W-1:0]   hash_fwd;
        logic [HASH_W-1:0]   hash_rc;
        logic                ovf;
        logic [LETTER_W-1:0] letter;
        logic                eor;
    } t_codec_result;

    // -----------------------------------------------------------------------
    // scoreboard: own copy of the k-mer state and of max_bases
    // -----------------------------------------------------------------------
    class t_kmer_scoreboard;
        t_codec_result      expected_q[$];
        logic [CFG_W-1:0]   max_bases;
        logic [HASH_W-1:0]  fwd_acc;
        logic [HASH_W-1:0]  rc_acc;
        logic [HASH_W-1:0]  pow10;
        int unsigned        bases_taken;
        logic               ovf_seen;

        function new();
            max_bases = MAX_BASES_RST;
            clear_kmer();
        endfunction

        function void clear_kmer();
            fwd_acc     = '0;
            rc_acc      = '0;
            pow10       = 64'd1;
            bases_taken = 0;
            ovf_seen    = 1'b0;
        endfunction

        function void set_max_bases(logic [CFG_W-1:0] v);
            max_bases = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [DIGIT_W-1:0] base_to_digit(logic [BASE_W-1:0] b, bit comp);
            case (b)
                "A":     return comp ? 4'd4 : 4'd1;
                "C":     return comp ? 4'd3 : 4'd2;
                "G":     return comp ? 4'd2 : 4'd3;
                "T":     return comp ? 4'd1 : 4'd4;
                "a":     return comp ? 4'd9 : 4'd6;
                "c":     return comp ? 4'd8 : 4'd7;
                "g":     return comp ? 4'd7 : 4'd8;
                "t":     return comp ? 4'd6 : 4'd9;
                default: return 4'd5;
            endcase
        endfunction

        function logic [LETTER_W-1:0] digit_letter(logic [DIGIT_W-1:0] d, bit comp);
            case (d)
                4'd1:    return comp ? "T" : "A";
                4'd2:    return comp ? "G" : "C";
                4'd3:    return comp ? "C" : "G";
                4'd4:    return comp ? "A" : "T";
                4'd6:    return comp ? "t" : "a";
                4'd7:    return comp ? "g" : "c";
                4'd8:    return comp ? "c" : "g";
                4'd9:    return comp ? "a" : "t";
                default: return "N";
            endcase
        endfunction

        function void note_input(logic [MODE_W-1:0] mode, logic [BASE_W-1:0] base,
                                 logic last, logic [CODE_W-1:0] code);
            int unsigned         lim;
            logic [DIGIT_W-1:0]  d;
            logic [DIGIT_W-1:0]  c;
            logic [127:0]        wide;
            logic [HASH_W-1:0]   prod;
            logic [CODE_W-1:0]   v;
            logic [DIGIT_W-1:0]  digits[$];
            int                  n;
            t_codec_result       r;
            case (mode)
                MODE_ENCODE: begin
                    lim = max_bases;
                    if (lim < 1) lim = 1;
                    if (lim > MAX_DIGITS_DEF) lim = MAX_DIGITS_DEF;
                    if (bases_taken < lim) begin
                        d    = base_to_digit(base, 1'b0);
                        c    = base_to_digit(base, 1'b1);
                        wide = 128'(fwd_acc) * 10 + 128'(d);
                        if (wide[127:64] != '0) ovf_seen = 1'b1;
                        fwd_acc = wide[63:0];
                        wide = 128'(pow10) * 128'(c);
                        if (wide[127:64] != '0) ovf_seen = 1'b1;
                        prod = wide[63:0];
                        wide = 128'(rc_acc) + 128'(prod);
                        if (wide[64]) ovf_seen = 1'b1;
                        rc_acc = wide[63:0];
                        // the power may wrap without raising the flag
                        pow10 = pow10 * 64'd10;
                        bases_taken++;
                    end
                    if (last) begin
                        r          = '0;
                        r.hash_fwd = fwd_acc;
                        r.hash_rc  = rc_acc;
                        r.ovf      = ovf_seen;
                        r.eor      = 1'b1;
                        expected_q.insert(expected_q.size(), r);
                        clear_kmer();
                    end
                end
                MODE_DEC_FWD, MODE_DEC_RC: begin
                    v = code;
                    do begin
                        digits.insert(digits.size(), DIGIT_W'(v % 64'd10));
                        v = v / 64'd10;
                    end while (v != '0 && digits.size() < MAX_DIGITS_DEF);
                    n = digits.size();
                    for (int k = 0; k < n; k++) begin
                        r      = '0;
                        r.kind = 1'b1;
                        if (mode == MODE_DEC_FWD)
                            r.letter = digit_letter(digits[n-1-k], 1'b0);
                        else
                            r.letter = digit_letter(digits[k], 1'b1);
                        r.eor = (k == n - 1);
                        expected_q.insert(expected_q.size(), r);
                    end
                end
                default: ;
            endcase
        endfunction

        function bit check_result(t_codec_result got, output string msg);
            t_codec_result want;
            want = expected_q.pop_front();
            msg  = "";
            if (got.kind != want.kind)
                msg = {msg, $sformatf(" kind %0d/%0d", got.kind, want.kind)};
            if (got.hash_fwd != want.hash_fwd)
                msg = {msg, $sformatf(" fwd %0d/%0d", got.hash_fwd, want.hash_fwd)};
            if (got.hash_rc != want.hash_rc)
                msg = {msg, $sformatf(" rc %0d/%0d", got.hash_rc, want.hash_rc)};
            if (got.ovf != want.ovf)
                msg = {msg, $sformatf(" ovf %0d/%0d", got.ovf, want.ovf)};
            if (got.letter != want.letter)
                msg = {msg, $sformatf(" letter %h/%h", got.letter, want.letter)};
            if (got.eor != want.eor)
                msg = {msg, $sformatf(" last %0d/%0d", got.eor, want.eor)};
            return (msg == "");
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // block signals, all inputs known from time zero
    // -----------------------------------------------------------------------
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]     i_cfg_wr_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;   // base[7:0], code[71:8]
    logic                 s_axis_tlast  = 1'b0; // last
    logic [MODE_W-1:0]    s_axis_tuser  = '0;   // mode[1:0]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;         // hash_fwd[63:0], hash_rc[127:64],
                                                // ovf[128], letter[136:129], zeros
    logic                 m_axis_tlast;         // end_of_run
    logic                 m_axis_tuser;         // kind

    t_kmer_scoreboard sb = new();

    int          mismatch_count   = 0;
    int          sent_items       = 0;
    int          idle_cycles      = 0;
    int unsigned sender_idle_pct  = 0;
    int unsigned recv_stall_pct   = 0;
    bit          hold_pending     = 1'b0;  // stimulus asks for a hold-off
    bit          hold_req         = 1'b0;  // raised at the next input transfer
    int          hold_left        = 0;

    kmer_decimal_hash_codec_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch:%s", $realtime, what);
        mismatch_count++;
    endtask

    // -----------------------------------------------------------------------
    // receiver: random stalls, plus one long hold-off when requested
    // -----------------------------------------------------------------------
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // -----------------------------------------------------------------------
    // output monitor, sampled at the rising edge
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_codec_result got;
        string         msg;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind     = m_axis_tuser;
            got.hash_fwd = m_axis_tdata[63:0];
            got.hash_rc  = m_axis_tdata[127:64];
            got.ovf      = m_axis_tdata[128];
            got.letter   = m_axis_tdata[136:129];
            got.eor      = m_axis_tlast;
            if (sb.pending() == 0)
                report_mismatch($sformatf(" result with nothing expected, kind %0d",
                                          got.kind));
            else if (!sb.check_result(got, msg))
                report_mismatch(msg);
        end
    end

    // watchdog: any transfer on either side restarts the count
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // -----------------------------------------------------------------------
    // sender tasks, called and returning at a falling edge
    // -----------------------------------------------------------------------
    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [BASE_W-1:0] base,
                             input logic last, input logic [CODE_W-1:0] code);
        // random gap before the transfer
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {code, base};
        s_axis_tlast  <= last;
        s_axis_tuser  <= mode;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_input(mode, base, last, code);
        if (mode != MODE_RESERVED) sent_items++;
        if (hold_pending) begin
            hold_req     = 1'b1;
            hold_pending = 1'b0;
        end
        @(negedge i_clk);
    endtask

    function automatic logic [CODE_W-1:0] junk64();
        return {$urandom, $urandom};
    endfunction

    // mostly proper bases, now and then any byte at all
    function automatic logic [BASE_W-1:0] pick_base();
        logic [BASE_W-1:0] bases[8];
        bases = '{"A", "C", "G", "T", "a", "c", "g", "t"};
        if ($urandom_range(0, 99) < 80) return bases[$urandom_range(0, 7)];
        return BASE_W'($urandom);
    endfunction

    // mix of short, wide-ranged and full 64-bit values and powers of ten, some minus one
    function automatic logic [CODE_W-1:0] pick_code();
        logic [CODE_W-1:0] p;
        case ($urandom_range(0, 3))
            0: return junk64();
            1: return CODE_W'($urandom_range(0, 999));
            2: return junk64() >> $urandom_range(0, 63);
            default: begin
                p = 64'd1;
                repeat ($urandom_range(0, 19)) p = p * 64'd10;
                return p - CODE_W'($urandom_range(0, 1));
            end
        endcase
    endfunction

    task automatic send_kmer(input int len);
        for (int i = 0; i < len; i++)
            send_item(MODE_ENCODE, pick_base(), (i == len - 1), junk64());
    endtask

    // wait for every expected result plus the block's worst latency
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_max_bases(input logic [CFG_W-1:0] v);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.set_max_bases(v);
    endtask

    task automatic set_idling(input t_idling m);
        case (m)
            IDLE_NONE:     begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER:   begin sender_idle_pct = 76; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin sender_idle_pct = 0;  recv_stall_pct = 76; end
            default:       begin sender_idle_pct = 15; recv_stall_pct = 15; end
        endcase
    endtask

    // -----------------------------------------------------------------------
    // stimulus
    // -----------------------------------------------------------------------
    initial begin : stimulus
        logic [CFG_W-1:0] cfg_plan[8];
        int               target;
        int unsigned      pick;

        set_idling(IDLE_BOTH);
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: every base letter once, one k-mer at the reset limit
        send_item(MODE_ENCODE, "A", 1'b0, junk64());
        send_item(MODE_ENCODE, "C", 1'b0, junk64());
        send_item(MODE_ENCODE, "G", 1'b0, junk64());
        send_item(MODE_ENCODE, "T", 1'b0, junk64());
        send_item(MODE_ENCODE, "a", 1'b0, junk64());
        send_item(MODE_ENCODE, "c", 1'b0, junk64());
        send_item(MODE_ENCODE, "g", 1'b0, junk64());
        send_item(MODE_ENCODE, "t", 1'b1, junk64());
        // bytes that are no base fold in as digit five
        send_item(MODE_ENCODE, 8'h00, 1'b0, '0);
        send_item(MODE_ENCODE, 8'hFF, 1'b0, '1);
        send_item(MODE_ENCODE, "N", 1'b0, junk64());
        send_item(MODE_ENCODE, "x", 1'b1, junk64());
        // reserved mode is dropped, then a single-base k-mer
        send_item(MODE_RESERVED, 8'hFF, 1'b1, '1);
        send_item(MODE_ENCODE, "t", 1'b1, junk64());
        // decode of zero, of the largest value, zero and five digits inside
        send_item(MODE_DEC_FWD, 8'h00, 1'b0, '0);
        send_item(MODE_DEC_RC, 8'hFF, 1'b1, '0);
        send_item(MODE_DEC_FWD, 8'h5A, 1'b1, '1);
        send_item(MODE_DEC_RC, 8'hA5, 1'b0, '1);
        send_item(MODE_DEC_FWD, "A", 1'b0, 64'd1234567890);
        send_item(MODE_DEC_RC, "C", 1'b1, 64'd10000000000000000000);
        // bases past a small limit are dropped, last still gives the hash
        write_max_bases(5'd2);
        send_item(MODE_ENCODE, "G", 1'b0, junk64());
        send_item(MODE_ENCODE, "c", 1'b0, junk64());
        send_item(MODE_ENCODE, "T", 1'b0, junk64());
        send_item(MODE_ENCODE, "a", 1'b1, junk64());

        // random phases: each one a new max_bases and a new idling pattern
        cfg_plan = '{5'd31, 5'd1, 5'd0, 5'd20, 5'd9, CFG_W'($urandom_range(0, 31)),
                     5'd3, 5'd20};
        for (int p = 0; p < 8; p++) begin
            write_max_bases(cfg_plan[p]);
            set_idling(t_idling'(p % 4));
            // long receiver hold-off in the phase without idling
            if (p == 0) hold_pending = 1'b1;
            target = sent_items + PHASE_ITEMS;
            while (sent_items < target) begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    send_kmer($urandom_range(1, 24));
                end else if (pick < 85) begin
                    send_item($urandom_range(0, 1) ? MODE_DEC_FWD : MODE_DEC_RC,
                              BASE_W'($urandom), 1'($urandom), pick_code());
                end else if (pick < 92) begin
                    // broken k-mer, runs on into the next one
                    repeat ($urandom_range(1, 3))
                        send_item(MODE_ENCODE, pick_base(), 1'b0, junk64());
                end else begin
                    send_item(MODE_RESERVED, BASE_W'($urandom), 1'($urandom), junk64());
                end
            end
        end

        drain();
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
